// ===== sv/mie_pkg.sv =====
`timescale 1ns / 1ps

package mie_pkg;

  // Default operand width
  localparam int OPERAND_BITS_DEF = 31;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_QUO,
    ST_UPDATE,
    ST_RED,
    ST_RDIV,
    ST_FINISH
  } mie_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // take a new word into the working registers
    logic start_quo;  // start a Euclid division r0 / r1
    logic update;     // advance remainders and coefficients
    logic start_red;  // start reduction of the coefficient by the modulus
    logic publish;    // load the output register
  } mie_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic rem_zero;   // r1 is zero, Euclid loop is finished
    logic div_done;   // divider finished, remainder and product q * s1 ready
    logic mod_zero;   // modulus is zero, no reduction possible
    logic out_free;   // output register can take a word this cycle
  } mie_sts_t;

endpackage

// ===== sv/modular_inverse_ext_euclid.sv =====
`timescale 1ns / 1ps

// Channel  Valid      Stall      Fields
// in       in_valid   in_stall   value, modulus
// out      out_valid  out_stall  inverse, divisor, invertible
//
// One word at a time: each Euclid step is a loop test, a bit-serial division,
// its done flag and the update; accept, the last loop test, reduction and publish
// complete the word. The bit-serial divider dominates the time per word.
// rst is synchronous and clears the controller, the divider flags and out_valid.
// A held result does not block the next input word; a second one waits to publish.

module modular_inverse_ext_euclid #(
  parameter int OPERAND_BITS = mie_pkg::OPERAND_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OPERAND_BITS-1:0] value,
  input  logic [OPERAND_BITS-1:0] modulus,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [OPERAND_BITS-1:0] inverse,
  output logic [OPERAND_BITS-1:0] divisor,
  output logic                    invertible
);

  import mie_pkg::*;

  mie_cmd_t cmd;
  mie_sts_t sts;

  mie_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mie_dp #(
    .N (OPERAND_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .value      (value),
    .modulus    (modulus),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .inverse    (inverse),
    .divisor    (divisor),
    .invertible (invertible)
  );

endmodule

// ===== sv/mie_div.sv =====
`timescale 1ns / 1ps

module mie_div #(
  parameter int N  = 31,
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [N-1:0]  divisor,
  output logic          step,
  output logic          qbit,
  output logic          done,
  output logic [N-1:0]  rem
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   dvd;
  logic [N-1:0]    dsr;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [N:0]      trial;
  logic [N:0]      diff;
  logic            last;

  // Trial subtract of the shifted partial remainder
  assign trial = {rem, dvd[DW-1]};
  assign diff  = trial - {1'b0, dsr};
  assign qbit  = (trial >= {1'b0, dsr});
  assign step  = busy;
  assign last  = busy && (cnt == CNTW'(1));

  // Busy and done flags
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= last;
      if (start) begin
        busy <= 1'b1;
      end else if (last) begin
        busy <= 1'b0;
      end
    end
  end

  // One quotient bit per cycle, MSB first
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      cnt <= CNTW'(DW);
    end else if (busy) begin
      dvd <= {dvd[DW-2:0], 1'b0};
      rem <= qbit ? diff[N-1:0] : trial[N-1:0];
      cnt <= cnt - CNTW'(1);
    end
  end

endmodule

// ===== sv/mie_dp.sv =====
`timescale 1ns / 1ps

module mie_dp #(
  parameter int N = 31
) (
  input  logic                clk,
  input  logic                rst,
  input  mie_pkg::mie_cmd_t   cmd,
  output mie_pkg::mie_sts_t   sts,
  input  logic [N-1:0]        value,
  input  logic [N-1:0]        modulus,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [N-1:0]        inverse,
  output logic [N-1:0]        divisor,
  output logic                invertible
);

  import mie_pkg::*;

  // Coefficients are two's complement, two bits wider than the operands
  localparam int DW = N + 2;

  logic [N-1:0]  r0;
  logic [N-1:0]  r1;
  logic [N-1:0]  m;
  logic [DW-1:0] s0;
  logic [DW-1:0] s1;
  logic [DW-1:0] acc;
  logic          sneg;

  logic          div_start;
  logic [DW-1:0] div_dividend;
  logic [N-1:0]  div_divisor;
  logic          div_step;
  logic          div_qbit;
  logic          div_done;
  logic [N-1:0]  div_rem;
  logic [DW-1:0] mag;
  logic [N-1:0]  inv_calc;

  // Shared divider: Euclid quotients and the final reduction
  mie_div #(
    .N  (N),
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .step     (div_step),
    .qbit     (div_qbit),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Magnitude of the coefficient for reduction
  assign mag = s0[DW-1] ? ((~s0) + DW'(1)) : s0;

  assign div_start    = cmd.start_quo | cmd.start_red;
  assign div_dividend = cmd.start_red ? mag : {2'b00, r0};
  assign div_divisor  = cmd.start_red ? m : r1;

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r0 <= value;
      r1 <= modulus;
      m  <= modulus;
      s0 <= DW'(1);
      s1 <= '0;
    end else if (cmd.update) begin
      r0 <= r1;
      r1 <= div_rem;
      s0 <= s1;
      s1 <= s0 - acc;
    end
  end

  // Accumulate q * s1 as quotient bits arrive
  always_ff @(posedge clk) begin
    if (cmd.start_quo) begin
      acc <= '0;
    end else if (div_step) begin
      acc <= {acc[DW-2:0], 1'b0} + (div_qbit ? s1 : '0);
    end
  end

  // Remember the sign of the coefficient being reduced
  always_ff @(posedge clk) begin
    if (cmd.start_red) begin
      sneg <= s0[DW-1];
    end
  end

  // Fold a negative coefficient back into 0..m-1; a zero modulus gives 0
  always_comb begin
    if (m == '0) begin
      inv_calc = '0;
    end else if (sneg && (div_rem != '0)) begin
      inv_calc = m - div_rem;
    end else begin
      inv_calc = div_rem;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      inverse    <= inv_calc;
      divisor    <= r0;
      invertible <= (r0 == N'(1));
    end
  end

  assign sts.rem_zero = (r1 == '0);
  assign sts.div_done = div_done;
  assign sts.mod_zero = (m == '0);
  assign sts.out_free = !out_valid || !out_stall;

endmodule

// ===== sv/mie_ctrl.sv =====
`timescale 1ns / 1ps

module mie_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mie_pkg::mie_sts_t sts,
  output mie_pkg::mie_cmd_t cmd
);

  import mie_pkg::*;

  mie_state_t state;
  mie_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = sts.rem_zero ? ST_RED : ST_QUO;
      end
      ST_QUO: begin
        if (sts.div_done) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = ST_CHECK;
      end
      ST_RED: begin
        state_next = sts.mod_zero ? ST_FINISH : ST_RDIV;
      end
      ST_RDIV: begin
        if (sts.div_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE:   cmd.load      = in_valid;
      ST_CHECK:  cmd.start_quo = !sts.rem_zero;
      ST_UPDATE: cmd.update    = 1'b1;
      ST_RED:    cmd.start_red = !sts.mod_zero;
      ST_FINISH: cmd.publish   = sts.out_free;
      default:   cmd = '0;
    endcase
  end

  assign in_stall = (state != ST_IDLE);

`ifndef SYNTH
  // Remainders advance only once the division has finished
  a_update_after_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |-> $past(sts.div_done))
    else $error("update without a finished division");

  // Never overwrite a result that is still waiting
  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> sts.out_free)
    else $error("publish into a full output register");

  // A new word always starts with the loop test
  a_load_then_check: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_CHECK))
    else $error("load not followed by loop test");

  // Only one division start at a time
  a_single_start: assert property (@(posedge clk) disable iff (rst)
    !(cmd.start_quo && cmd.start_red))
    else $error("two division starts at once");
`endif

endmodule
